[src/rsiw_pkg.sv]
// rsiw_pkg: shared constants, widths and divider handshake types for the
// Wilder-smoothed RSI block. No dependencies.
package rsiw_pkg;

  localparam int RSIW_PRICE_BITS = 32;
  localparam int RSIW_FRAC_BITS  = 16;

  localparam int PRICE_W  = 32;
  localparam int PERIOD_W = 8;
  localparam int STORE_W  = 48;
  localparam int RSI_W    = 14;
  localparam int COUNT_W  = 9;
  localparam int MUL_B_W  = 14;
  localparam int MUL_W    = STORE_W + MUL_B_W;
  localparam int DIV_W    = 64;
  localparam int DVS_W    = STORE_W + 1;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd14;
  localparam logic [RSI_W-1:0]    RSI_FULL     = 14'd10000;
  localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

[src/rsiw_div.sv]
// rsiw_div: shared restoring divider, one quotient bit per cycle.
// Depends on rsiw_pkg.
module rsiw_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rsiw_pkg::div_req_t req_i,
  output rsiw_pkg::div_rsp_t rsp_o
);
  import rsiw_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DVS_W-1:0]     rem_q;
  logic [DVS_W-1:0]     dvs_q;
  logic [DIV_W-1:0]     dq_q;

  logic [DVS_W:0]       trial;
  logic                 ge;
  logic [DVS_W:0]       diff;

  // shift next dividend bit into the partial remainder, subtract if it fits
  assign trial = {rem_q, dq_q[DIV_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dvs_q <= req_i.divisor;
      dq_q  <= req_i.dividend;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      dq_q  <= {dq_q[DIV_W-2:0], ge};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dq_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("done without a finished division");

  a_no_zero_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> req_i.divisor != '0)
    else $error("division by zero requested");

endmodule

[src/rsiw_core.sv]
// rsiw_core: sequencer, price/count/store state and operand selection.
// Depends on rsiw_pkg; drives the shared rsiw_div through div_req_t/div_rsp_t.
module rsiw_core #(
  parameter int PRICE_BITS = rsiw_pkg::RSIW_PRICE_BITS,
  parameter int FRAC_BITS  = rsiw_pkg::RSIW_FRAC_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [rsiw_pkg::PERIOD_W-1:0]   period_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [rsiw_pkg::PRICE_W-1:0]    price_i,
  input  logic                            restart_i,
  output logic                            res_valid_o,
  input  logic                            res_ready_i,
  output logic [rsiw_pkg::RSI_W-1:0]      rsi_o,
  output logic [rsiw_pkg::STORE_W-1:0]    gain_o,
  output logic [rsiw_pkg::STORE_W-1:0]    loss_o,
  output rsiw_pkg::div_req_t              div_req_o,
  input  rsiw_pkg::div_rsp_t              div_rsp_i
);
  import rsiw_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_MUL      = 3'd1;
  localparam logic [2:0] S_DIV_GO   = 3'd2;
  localparam logic [2:0] S_DIV_WAIT = 3'd3;
  localparam logic [2:0] S_RSI_MUL  = 3'd4;
  localparam logic [2:0] S_RSI_GO   = 3'd5;
  localparam logic [2:0] S_RSI_WAIT = 3'd6;
  localparam logic [2:0] S_OUT      = 3'd7;

  logic [2:0]            state_q, state_d;
  logic [PRICE_BITS-1:0] last_q;
  logic [COUNT_W-1:0]    cnt_q;
  logic [STORE_W-1:0]    gs_q, ls_q;
  logic [PRICE_BITS-1:0] gain_q, loss_q;
  logic                  loss_sel_q;
  logic                  avg_mode_q;
  logic [MUL_W-1:0]      mul_q;
  logic [DVS_W-1:0]      sum_q;
  logic [RSI_W-1:0]      rsi_q;

  logic [PERIOD_W-1:0]   p_eff;
  logic [PERIOD_W-1:0]   pm1;
  logic [COUNT_W-1:0]    p_cnt;
  logic [PRICE_BITS-1:0] price_m;
  logic [PRICE_BITS-1:0] gain_c, loss_c;
  logic [STORE_W-1:0]    cur_store;
  logic [PRICE_BITS-1:0] cur_x;
  logic [STORE_W-1:0]    mul_a;
  logic [MUL_B_W-1:0]    mul_b;
  logic [MUL_W-1:0]      mul_p;
  logic                  accept;
  logic                  first_item;

  // period 0 behaves as 1
  assign p_eff   = (period_i == '0) ? PERIOD_W'(1) : period_i;
  assign pm1     = p_eff - 1'b1;
  assign p_cnt   = COUNT_W'(p_eff);
  assign price_m = price_i[PRICE_BITS-1:0];
  assign gain_c  = (price_m > last_q) ? price_m - last_q : '0;
  assign loss_c  = (price_m < last_q) ? last_q - price_m : '0;

  assign cur_store = loss_sel_q ? ls_q : gs_q;
  assign cur_x     = loss_sel_q ? loss_q : gain_q;

  // one multiplier: store * (P-1) for smoothing, gain * 10000 for the index
  assign mul_a = (state_q == S_RSI_MUL) ? gs_q : cur_store;
  assign mul_b = (state_q == S_RSI_MUL) ? MUL_B_W'(RSI_FULL) : MUL_B_W'(pm1);
  assign mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign first_item = restart_i || (cnt_q == '0);

  always_comb begin
    div_req_o.start    = (state_q == S_DIV_GO) || (state_q == S_RSI_GO);
    div_req_o.divisor  = DVS_W'(p_eff);
    div_req_o.dividend = DIV_W'(mul_q) + (DIV_W'(cur_x) << FRAC_BITS);
    if (state_q == S_RSI_GO) begin
      div_req_o.divisor  = sum_q;
      div_req_o.dividend = DIV_W'(mul_q);
    end else if (avg_mode_q) begin
      div_req_o.dividend = DIV_W'(cur_store) << FRAC_BITS;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && !first_item) begin
          if (cnt_q == p_cnt) begin
            state_d = S_DIV_GO;
          end else if (cnt_q > p_cnt) begin
            state_d = S_MUL;
          end
        end
      end
      S_MUL:      state_d = S_DIV_GO;
      S_DIV_GO:   state_d = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_rsp_i.done) begin
          if (!loss_sel_q) begin
            state_d = avg_mode_q ? S_DIV_GO : S_MUL;
          end else begin
            state_d = avg_mode_q ? S_IDLE : S_RSI_MUL;
          end
        end
      end
      S_RSI_MUL:  state_d = (ls_q == '0) ? S_OUT : S_RSI_GO;
      S_RSI_GO:   state_d = S_RSI_WAIT;
      S_RSI_WAIT: begin
        if (div_rsp_i.done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default:    state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      last_q     <= '0;
      cnt_q      <= '0;
      gs_q       <= '0;
      ls_q       <= '0;
      loss_sel_q <= 1'b0;
      avg_mode_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        last_q     <= price_m;
        loss_sel_q <= 1'b0;
        avg_mode_q <= (cnt_q == p_cnt);
        if (first_item) begin
          cnt_q <= COUNT_W'(1);
          gs_q  <= '0;
          ls_q  <= '0;
        end else begin
          if (cnt_q != COUNT_MAX) begin
            cnt_q <= cnt_q + 1'b1;
          end
          // still summing the first P changes
          if (cnt_q <= p_cnt) begin
            gs_q <= gs_q + STORE_W'(gain_c);
            ls_q <= ls_q + STORE_W'(loss_c);
          end
        end
      end else if (state_q == S_DIV_WAIT && div_rsp_i.done) begin
        loss_sel_q <= 1'b1;
        if (loss_sel_q) begin
          ls_q <= div_rsp_i.quotient[STORE_W-1:0];
        end else begin
          gs_q <= div_rsp_i.quotient[STORE_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      gain_q <= gain_c;
      loss_q <= loss_c;
    end
    if (state_q == S_MUL) begin
      mul_q <= mul_p;
    end
    if (state_q == S_RSI_MUL) begin
      mul_q <= mul_p;
      sum_q <= DVS_W'(gs_q) + DVS_W'(ls_q);
      rsi_q <= RSI_FULL;
    end
    if (state_q == S_RSI_WAIT && div_rsp_i.done) begin
      rsi_q <= div_rsp_i.quotient[RSI_W-1:0];
    end
  end

  assign res_valid_o = (state_q == S_OUT);
  assign rsi_o       = rsi_q;
  assign gain_o      = gs_q;
  assign loss_o      = ls_q;

  a_zero_loss_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && ls_q == '0) |-> rsi_o == RSI_FULL)
    else $error("zero average loss must give full index");

  a_rsi_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> rsi_o <= RSI_FULL)
    else $error("index above full scale");

  a_restart_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && restart_i) |=> cnt_q == COUNT_W'(1))
    else $error("restart did not begin a new series");

  a_busy_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> cnt_q > p_cnt || (avg_mode_q && cnt_q != '0))
    else $error("division sequence without a valid sample count");

endmodule

[src/rsi_wilder_smoothing_unit.sv]
// rsi_wilder_smoothing_unit: top level, period register, output register.
// Warm-up prices run no division; the price that closes the first P changes runs
// 2 divisions before the next price is taken. Each later price runs 3 divisions (2 when
// the average loss is zero) before the word goes out and the next price is taken;
// a held output word adds its stall.
// Reset (rst_ni, async low) clears the series and sets the period to 14.
module rsi_wilder_smoothing_unit #(
  parameter int PRICE_BITS = rsiw_pkg::RSIW_PRICE_BITS,
  parameter int FRAC_BITS  = rsiw_pkg::RSIW_FRAC_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // period register write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rsiw_pkg::PERIOD_W-1:0]  cfg_data_i,
  // price input channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [rsiw_pkg::PRICE_W-1:0]   price_i,
  input  logic                           restart_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [rsiw_pkg::RSI_W-1:0]     rsi_hundredths_o,
  output logic [rsiw_pkg::STORE_W-1:0]   average_gain_o,
  output logic [rsiw_pkg::STORE_W-1:0]   average_loss_o
);
  import rsiw_pkg::*;

  logic [PERIOD_W-1:0] period_q;

  logic                res_valid;
  logic                res_ready;
  logic [RSI_W-1:0]    res_rsi;
  logic [STORE_W-1:0]  res_gain;
  logic [STORE_W-1:0]  res_loss;

  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic                out_valid_q;
  logic [RSI_W-1:0]    out_rsi_q;
  logic [STORE_W-1:0]  out_gain_q;
  logic [STORE_W-1:0]  out_loss_q;

  // Period register: the user must write it only while idle; the block does not enforce this, so always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RESET;
    end else if (cfg_valid_i) begin
      period_q <= cfg_data_i;
    end
  end

  rsiw_core #(
    .PRICE_BITS (PRICE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .period_i    (period_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .price_i     (price_i),
    .restart_i   (restart_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .rsi_o       (res_rsi),
    .gain_o      (res_gain),
    .loss_o      (res_loss),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp)
  );

  rsiw_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Output register: the core can take the next price while a result word
  // waits here; a new result loads when the slot is empty or being drained.
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_rsi_q  <= res_rsi;
      out_gain_q <= res_gain;
      out_loss_q <= res_loss;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign rsi_hundredths_o = out_rsi_q;
  assign average_gain_o   = out_gain_q;
  assign average_loss_o   = out_loss_q;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q && $stable(out_rsi_q))
    else $error("stalled result word changed");

  a_period_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> period_q == PERIOD_RESET)
    else $error("period not at reset value");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready) |=> out_valid_q && out_rsi_q == $past(res_rsi))
    else $error("result word not captured");

endmodule
